// ===== design/gww_pkg.sv =====
// ----------------------------------------------------------------------------
// gww_pkg: shared types and constants of the greedy word wrapper
// Transaction payloads, request codes and the command and status groups
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gww_pkg;

  localparam int LINE_WIDTH_DEF = 78;
  localparam int BYTES_PER_WORD = 8;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_END  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] ch;
  } char_item_t;

  typedef struct packed {
    logic [63:0] chars;
    logic [3:0]  char_count;
    logic        end_of_line;
    logic        end_of_text;
  } word_item_t;

  typedef struct packed {
    logic accept;
    logic read;
    logic put;
  } gww_cmd_t;

  typedef struct packed {
    logic line_start;
    logic word_full;
    logic pend;
    logic line_last;
    logic out_free;
  } gww_status_t;

endpackage

`default_nettype wire

// ===== design/gww_ctrl.sv =====
// ----------------------------------------------------------------------------
// gww_ctrl: controller of the greedy word wrapper
// Takes characters while idle and, once a line is cut, steps the datapath
// through fetching and handing out each packed word of the line.
// ----------------------------------------------------------------------------
`default_nettype none

module gww_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  char_valid,
  output logic                 char_ready,
  input  gww_pkg::gww_status_t status,
  output gww_pkg::gww_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PUT
  } state_t;

  state_t state;

  always_comb begin
    cmd.accept = char_valid && char_ready;
    cmd.read   = (state == ST_FETCH) && !status.word_full;
    cmd.put    = (state == ST_PUT) && status.out_free && !status.pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_ready <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.accept && status.line_start) begin
            state      <= ST_FETCH;
            char_ready <= 1'b0;
          end
        end
        ST_FETCH: begin
          if (status.word_full) begin
            state <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (cmd.put) begin
            if (status.line_last) begin
              state      <= ST_IDLE;
              char_ready <= 1'b1;
            end else begin
              state <= ST_FETCH;
            end
          end
        end
        default: begin
          state      <= ST_IDLE;
          char_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/gww_datapath.sv =====
// ----------------------------------------------------------------------------
// gww_datapath: line buffer and word packer of the greedy word wrapper
// A circular line buffer with running space trackers decides each cut as a
// character arrives; a cut line is read into words a byte per fetch cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gww_datapath #(
  parameter int LINE_WIDTH = gww_pkg::LINE_WIDTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  gww_pkg::char_item_t   char_item,
  input  gww_pkg::gww_cmd_t     cmd,
  output gww_pkg::gww_status_t  status,
  output logic                  word_valid,
  input  wire                   word_ready,
  output gww_pkg::word_item_t   word_item
);

  localparam int AW = $clog2(LINE_WIDTH);
  localparam int CW = $clog2(LINE_WIDTH + 1);

  logic [7:0]    mem [LINE_WIDTH];
  logic [7:0]    rdata;

  logic [AW-1:0] head;
  logic [CW-1:0] fill;
  logic          sp_valid;
  logic [AW-1:0] last_sp;
  logic [CW-1:0] sp_trim;
  logic [CW-1:0] last_nonsp;

  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] left;
  logic          final_line;
  logic [3:0]    wcnt;
  logic          pend;
  logic [2:0]    pend_idx;
  logic [63:0]   asm_word;

  logic          is_space;
  logic          is_end;
  logic          full_now;
  logic          sp_valid_new;
  logic [AW-1:0] last_sp_new;
  logic [CW-1:0] sp_trim_new;
  logic [AW:0]   wr_sum;
  logic [AW-1:0] wr_addr;
  logic [AW:0]   head_sum;
  logic [AW-1:0] head_next;
  logic [CW-1:0] keep;
  logic [AW-1:0] rd_ptr_next;

  always_comb begin
    is_space     = (char_item.ch == gww_pkg::SPACE_CHAR);
    is_end       = (char_item.req_type == gww_pkg::REQ_END);
    full_now     = (fill == CW'(LINE_WIDTH - 1));
    sp_valid_new = is_space || sp_valid;
    last_sp_new  = is_space ? fill[AW-1:0] : last_sp;
    sp_trim_new  = is_space ? last_nonsp : sp_trim;

    wr_sum  = {1'b0, head} + {1'b0, fill[AW-1:0]};
    wr_addr = (wr_sum >= (AW+1)'(LINE_WIDTH)) ?
              AW'(wr_sum - (AW+1)'(LINE_WIDTH)) : wr_sum[AW-1:0];

    head_sum  = {1'b0, head} + {1'b0, last_sp_new} + (AW+1)'(1);
    head_next = (head_sum >= (AW+1)'(LINE_WIDTH)) ?
                AW'(head_sum - (AW+1)'(LINE_WIDTH)) : head_sum[AW-1:0];
    keep      = CW'(LINE_WIDTH - 1) - CW'(last_sp_new);

    rd_ptr_next = (rd_ptr == AW'(LINE_WIDTH - 1)) ? '0 : rd_ptr + AW'(1);

    status.line_start = is_end || full_now;
    status.word_full  = (left == '0) || (wcnt == 4'(gww_pkg::BYTES_PER_WORD));
    status.pend       = pend;
    status.line_last  = (left == '0);
    status.out_free   = !word_valid || word_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !is_end) begin
      mem[wr_addr] <= char_item.ch;
    end
    if (cmd.read) begin
      rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      fill       <= '0;
      sp_valid   <= 1'b0;
      last_nonsp <= '0;
      left       <= '0;
      wcnt       <= '0;
      pend       <= 1'b0;
      word_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        rd_ptr   <= head;
        wcnt     <= '0;
        asm_word <= '0;
        pend     <= 1'b0;
        if (is_end) begin
          left       <= fill;
          final_line <= 1'b1;
          fill       <= '0;
          sp_valid   <= 1'b0;
          last_nonsp <= '0;
        end else if (full_now) begin
          final_line <= 1'b0;
          if (sp_valid_new) begin
            left       <= (sp_trim_new == '0) ? '0 : sp_trim_new + CW'(1);
            head       <= head_next;
            fill       <= keep;
            last_nonsp <= keep;
            sp_valid   <= 1'b0;
          end else begin
            left       <= CW'(LINE_WIDTH);
            fill       <= '0;
            last_nonsp <= '0;
            sp_valid   <= 1'b0;
          end
        end else begin
          fill     <= fill + CW'(1);
          sp_valid <= sp_valid_new;
          last_sp  <= last_sp_new;
          sp_trim  <= sp_trim_new;
          if (!is_space) begin
            last_nonsp <= fill + CW'(1);
          end
        end
      end else begin
        pend <= cmd.read;
        if (cmd.read) begin
          rd_ptr   <= rd_ptr_next;
          left     <= left - CW'(1);
          wcnt     <= wcnt + 4'd1;
          pend_idx <= wcnt[2:0];
        end
        if (pend) begin
          asm_word[pend_idx*8 +: 8] <= rdata;
        end
        if (cmd.put) begin
          wcnt     <= '0;
          asm_word <= '0;
        end
      end

      if (cmd.put) begin
        word_valid            <= 1'b1;
        word_item.chars       <= asm_word;
        word_item.char_count  <= wcnt;
        word_item.end_of_line <= (left == '0);
        word_item.end_of_text <= (left == '0) && final_line;
      end else if (word_ready) begin
        word_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/greedy_word_wrap.sv =====
// ----------------------------------------------------------------------------
// greedy_word_wrap: streaming greedy word wrapper
// Wraps a character stream into lines of at most LINE_WIDTH characters and
// hands each line out packed up to eight characters per transaction.
//
//   channel  signals                          direction  payload
//   char     char_valid char_ready char_item  in         req_type, ch
//   word     word_valid word_ready word_item  out        chars, count, flags
//
// A character that does not complete a line leaves the controller idle and ready.
// A cut or end of text reads the line buffer one byte per cycle while a word is
// fetched, through its single read port; an empty line still gives one word.
// The output register lets a new character in while the last word waits.
// Reset (rst, synchronous) empties the line buffer at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_word_wrap #(
  parameter int LINE_WIDTH = gww_pkg::LINE_WIDTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 char_valid,
  output logic                char_ready,
  input  gww_pkg::char_item_t char_item,
  output logic                word_valid,
  input  wire                 word_ready,
  output gww_pkg::word_item_t word_item
);

  gww_pkg::gww_cmd_t    cmd;
  gww_pkg::gww_status_t status;

  gww_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .status     (status),
    .cmd        (cmd)
  );

  gww_datapath #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .char_item  (char_item),
    .cmd        (cmd),
    .status     (status),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word_item  (word_item)
  );

endmodule

`default_nettype wire

// ===== design/gww_checker.sv =====
// ----------------------------------------------------------------------------
// gww_checker: port checks of the greedy word wrapper
// Watches the word channel for stalled transactions and for packing rules
// of lines, and the char channel for the stop after an end of text.
// ----------------------------------------------------------------------------
`default_nettype none

module gww_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 char_valid,
  input wire                 char_ready,
  input gww_pkg::char_item_t char_item,
  input wire                 word_valid,
  input wire                 word_ready,
  input gww_pkg::word_item_t word_item
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_ready |=> word_valid && $stable(word_item))
    else $error("Stalled word transaction changed or dropped.");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> word_item.char_count <= 4'd8)
    else $error("Word carries more than eight characters.");

  a_end_stops_input: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_ready && (char_item.req_type == gww_pkg::REQ_END) |=> !char_ready)
    else $error("Char channel still ready after an end of text.");

  a_inner_full: assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_item.end_of_line |-> word_item.char_count == 4'd8)
    else $error("Word inside a line is not full.");

  a_empty_is_line: assert property (@(posedge clk) disable iff (rst)
    word_valid && word_item.char_count == 4'd0 |->
      word_item.end_of_line && word_item.chars == 64'd0)
    else $error("Empty word that is not an empty line.");

endmodule

bind greedy_word_wrap gww_checker u_gww_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_ready (char_ready),
  .char_item  (char_item),
  .word_valid (word_valid),
  .word_ready (word_ready),
  .word_item  (word_item)
);

`default_nettype wire

// ===== bench/gww_checker.sv =====
// ----------------------------------------------------------------------------
// gww_scoreboard: scoreboard for the greedy word wrapper
// Watches the char and word channels. Every accepted char transaction runs
// through a local line-buffer model, and the packed words that the model
// cuts are queued. Each accepted word transaction is compared field by field
// with the oldest queued word.
// ----------------------------------------------------------------------------
module gww_scoreboard #(
  parameter int LINE_WIDTH = gww_pkg::LINE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  input  logic                char_ready,
  input  gww_pkg::char_item_t char_item,
  input  logic                word_valid,
  input  logic                word_ready,
  input  gww_pkg::word_item_t word_item,
  output int                  error_count,
  output int                  pending_count,
  output int                  chars_in,
  output int                  texts_in,
  output int                  words_out,
  output int                  lines_cut,
  output int                  hard_cuts,
  output int                  blank_lines
);

  logic [7:0]          line_buf [LINE_WIDTH];
  int                  fill;
  logic [7:0]          cut_q [$];
  gww_pkg::word_item_t expected_words [$];

  initial begin
    error_count   = 0;
    pending_count = 0;
    chars_in      = 0;
    texts_in      = 0;
    words_out     = 0;
    lines_cut     = 0;
    hard_cuts     = 0;
    blank_lines   = 0;
    fill          = 0;
  end

  task automatic report(input string what);
    error_count++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  task automatic trim_and_pad();
    while (cut_q.size() > 0 && cut_q[cut_q.size() - 1] == gww_pkg::SPACE_CHAR) begin
      void'(cut_q.pop_back());
    end
    if (cut_q.size() > 0) begin
      cut_q.push_back(gww_pkg::SPACE_CHAR);
    end
  endtask

  task automatic pack_line(input logic last_line);
    gww_pkg::word_item_t w;
    int                  pos;
    int                  n;
    pos = 0;
    lines_cut++;
    if (cut_q.size() == 0) begin
      blank_lines++;
    end
    do begin
      n = cut_q.size() - pos;
      if (n > gww_pkg::BYTES_PER_WORD) begin
        n = gww_pkg::BYTES_PER_WORD;
      end
      w = '0;
      for (int i = 0; i < n; i++) begin
        w.chars[8*i +: 8] = cut_q[pos + i];
      end
      pos += n;
      w.char_count  = 4'(n);
      w.end_of_line = (pos >= cut_q.size());
      w.end_of_text = w.end_of_line && last_line;
      expected_words.push_back(w);
    end while (pos < cut_q.size());
  endtask

  task automatic wrap_char(input gww_pkg::char_item_t it);
    int last_sp;
    int keep;
    last_sp = -1;
    cut_q.delete();
    if (it.req_type == gww_pkg::REQ_END) begin
      texts_in++;
      for (int i = 0; i < fill; i++) begin
        cut_q.push_back(line_buf[i]);
      end
      fill = 0;
      pack_line(1'b1);
    end else begin
      chars_in++;
      line_buf[fill] = it.ch;
      fill++;
      if (fill == LINE_WIDTH) begin
        for (int i = 0; i < LINE_WIDTH; i++) begin
          if (line_buf[i] == gww_pkg::SPACE_CHAR) begin
            last_sp = i;
          end
        end
        if (line_buf[LINE_WIDTH - 1] == gww_pkg::SPACE_CHAR) begin
          for (int i = 0; i < LINE_WIDTH; i++) begin
            cut_q.push_back(line_buf[i]);
          end
          trim_and_pad();
          fill = 0;
        end else if (last_sp < 0) begin
          for (int i = 0; i < LINE_WIDTH; i++) begin
            cut_q.push_back(line_buf[i]);
          end
          hard_cuts++;
          fill = 0;
        end else begin
          for (int i = 0; i < last_sp; i++) begin
            cut_q.push_back(line_buf[i]);
          end
          trim_and_pad();
          keep = LINE_WIDTH - 1 - last_sp;
          for (int i = 0; i < keep; i++) begin
            line_buf[i] = line_buf[last_sp + 1 + i];
          end
          fill = keep;
        end
        pack_line(1'b0);
      end
    end
  endtask

  task automatic check_word(input gww_pkg::word_item_t got);
    gww_pkg::word_item_t want;
    words_out++;
    if (expected_words.size() == 0) begin
      report($sformatf("unexpected word chars=%h count=%0d eol=%b eot=%b",
                       got.chars, got.char_count, got.end_of_line, got.end_of_text));
    end else begin
      want = expected_words.pop_front();
      if (got.chars !== want.chars) begin
        report($sformatf("word %0d chars %h, expected %h", words_out, got.chars, want.chars));
      end
      if (got.char_count !== want.char_count) begin
        report($sformatf("word %0d char_count %0d, expected %0d",
                         words_out, got.char_count, want.char_count));
      end
      if (got.end_of_line !== want.end_of_line) begin
        report($sformatf("word %0d end_of_line %b, expected %b",
                         words_out, got.end_of_line, want.end_of_line));
      end
      if (got.end_of_text !== want.end_of_text) begin
        report($sformatf("word %0d end_of_text %b, expected %b",
                         words_out, got.end_of_text, want.end_of_text));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      expected_words.delete();
    end else begin
      if (word_valid && word_ready) begin
        check_word(word_item);
      end
      if (char_valid && char_ready) begin
        wrap_char(char_item);
      end
    end
    pending_count = expected_words.size();
  end

endmodule

// ===== bench/tb_greedy_word_wrap.sv =====
// ----------------------------------------------------------------------------
// tb_greedy_word_wrap: testbench top of the greedy word wrapper
// Drives short directed texts and then random texts built from prose,
// sparse words, space-free runs, blank runs and byte noise, with random gaps
// on the char channel and random stalls on the word channel. The scoreboard
// beside the block predicts and compares every word transaction.
// ----------------------------------------------------------------------------
module tb_greedy_word_wrap;

  localparam int LINE_WIDTH   = gww_pkg::LINE_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 420;
  localparam int TAIL_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 500000;

  typedef enum int {
    MODE_PROSE,
    MODE_SPARSE,
    MODE_SOLID,
    MODE_BLANK,
    MODE_NOISE
  } text_mode_t;

  localparam int NUM_MODES = 5;

  logic                clk;
  logic                rst;
  logic                char_valid;
  logic                char_ready;
  gww_pkg::char_item_t char_item;
  logic                word_valid;
  logic                word_ready;
  gww_pkg::word_item_t word_item;

  int error_count;
  int pending_count;
  int chars_in;
  int texts_in;
  int words_out;
  int lines_cut;
  int hard_cuts;
  int blank_lines;

  int cycles = 0;
  int words_taken = 0;

  greedy_word_wrap #(
    .LINE_WIDTH(LINE_WIDTH)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_item (char_item),
    .word_valid(word_valid),
    .word_ready(word_ready),
    .word_item (word_item)
  );

  gww_scoreboard #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_scoreboard (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_item    (char_item),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .word_item    (word_item),
    .error_count  (error_count),
    .pending_count(pending_count),
    .chars_in     (chars_in),
    .texts_in     (texts_in),
    .words_out    (words_out),
    .lines_cut    (lines_cut),
    .hard_cuts    (hard_cuts),
    .blank_lines  (blank_lines)
  );

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    char_valid = 1'b0;
    char_item  = '0;
    word_ready = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycles, pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_char(input logic kind, input logic [7:0] c, input int gap);
    gww_pkg::char_item_t it;
    it.req_type = kind;
    it.ch       = c;
    @(negedge clk);
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_valid <= 1'b1;
    char_item  <= it;
    do @(posedge clk); while (!(char_valid && char_ready));
  endtask

  task automatic drain_words(input int hold);
    @(negedge clk);
    char_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (hold) @(negedge clk);
  endtask

  // Word channel: random stalls, with stretches of steady readiness.
  initial begin
    int stall;
    bit steady;
    steady = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (words_taken % 32 == 0) begin
        steady = ($urandom_range(0, 2) == 0);
      end
      stall = steady ? 0 : $urandom_range(0, 4);
      @(negedge clk);
      if (stall > 0) begin
        word_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      word_ready <= 1'b1;
      do @(posedge clk); while (!(word_valid && word_ready));
      words_taken++;
    end
  end

  initial begin
    text_mode_t mode;
    int         sent;
    int         text_idx;
    int         text_len;
    int         seg_left;
    int         word_left;
    int         space_left;
    bit         burst;
    logic [7:0] c;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // End of text on an empty buffer, byte extremes, zero byte and an
    // unstripped remainder with a trailing space.
    send_char(gww_pkg::REQ_END, 8'h00, 0);
    send_char(gww_pkg::REQ_CHAR, 8'h00, 0);
    send_char(gww_pkg::REQ_CHAR, 8'h01, 1);
    send_char(gww_pkg::REQ_CHAR, 8'hFF, 0);
    send_char(gww_pkg::REQ_CHAR, 8'h7F, 2);
    send_char(gww_pkg::REQ_CHAR, 8'h80, 0);
    send_char(gww_pkg::REQ_CHAR, gww_pkg::SPACE_CHAR, 0);
    send_char(gww_pkg::REQ_CHAR, gww_pkg::SPACE_CHAR, 3);
    send_char(gww_pkg::REQ_CHAR, 8'h41, 0);
    send_char(gww_pkg::REQ_CHAR, gww_pkg::SPACE_CHAR, 0);
    send_char(gww_pkg::REQ_END, 8'hFF, 4);
    send_char(gww_pkg::REQ_END, 8'hA5, 0);
    send_char(gww_pkg::REQ_CHAR, 8'h7A, 0);
    send_char(gww_pkg::REQ_CHAR, 8'hDF, 0);
    send_char(gww_pkg::REQ_END, 8'h5A, 1);
    drain_words(3);

    sent       = 0;
    text_idx   = 0;
    mode       = text_mode_t'($urandom_range(0, NUM_MODES - 1));
    seg_left   = 0;
    word_left  = 0;
    space_left = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 3) == 0);
      if (text_idx == 0) begin
        text_len = LINE_WIDTH;
        mode     = MODE_SOLID;
        seg_left = text_len;
      end else if (text_idx == 1) begin
        text_len = LINE_WIDTH;
        mode     = MODE_BLANK;
        seg_left = text_len;
      end else begin
        case ($urandom_range(0, 5))
          0: text_len = $urandom_range(0, 6);
          1: begin
            text_len = LINE_WIDTH;
            mode     = text_mode_t'($urandom_range(0, NUM_MODES - 1));
            seg_left = text_len;
          end
          default: text_len = $urandom_range(LINE_WIDTH + 1, 3 * LINE_WIDTH);
        endcase
      end
      if (text_len > RANDOM_ITEMS - 1 - sent) begin
        text_len = RANDOM_ITEMS - 1 - sent;
      end
      word_left  = $urandom_range(1, 12);
      space_left = 0;
      for (int k = 0; k < text_len; k++) begin
        if (seg_left == 0) begin
          mode = text_mode_t'((int'(mode) + 1) % NUM_MODES);
          case (mode)
            MODE_PROSE:  seg_left = $urandom_range(30, 90);
            MODE_SPARSE: seg_left = $urandom_range(20, 60);
            MODE_SOLID:  seg_left = $urandom_range(80, 120);
            MODE_BLANK:  seg_left = $urandom_range(80, 120);
            default:     seg_left = $urandom_range(10, 40);
          endcase
          word_left  = $urandom_range(1, 12);
          space_left = 0;
        end
        case (mode)
          MODE_PROSE, MODE_SPARSE: begin
            if (word_left > 0) begin
              c = 8'($urandom_range(33, 126));
              word_left--;
              if (word_left == 0) begin
                space_left = (mode == MODE_PROSE) ? $urandom_range(1, 2) : $urandom_range(1, 8);
              end
            end else begin
              c = gww_pkg::SPACE_CHAR;
              space_left--;
              if (space_left <= 0) begin
                word_left = (mode == MODE_PROSE) ? $urandom_range(1, 12) : $urandom_range(1, 6);
              end
            end
          end
          MODE_SOLID: begin
            c = 8'($urandom);
            if (c == gww_pkg::SPACE_CHAR) begin
              c = ~c;
            end
          end
          MODE_BLANK: c = gww_pkg::SPACE_CHAR;
          default: c = ($urandom_range(0, 3) == 0) ? gww_pkg::SPACE_CHAR : 8'($urandom);
        endcase
        send_char(gww_pkg::REQ_CHAR, c, burst ? 0 : $urandom_range(0, 4));
        seg_left--;
        sent++;
      end
      if (text_idx == 3) begin
        drain_words(5);
      end
      send_char(gww_pkg::REQ_END, 8'($urandom), burst ? 0 : $urandom_range(0, 4));
      sent++;
      text_idx++;
    end

    drain_words(TAIL_CYCLES);

    $display("Wrapped %0d characters in %0d texts into %0d lines and %0d words.",
             chars_in, texts_in, lines_cut, words_out);
    $display("Cuts without a space: %0d; empty lines: %0d; mismatches: %0d.",
             hard_cuts, blank_lines, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
